/* rtl/wlrr_pkg.sv */
`timescale 1ns / 1ps

package wlrr_pkg;

    // Record geometry
    localparam int REC_WORDS = 8;
    localparam int WORD_W    = 16;
    localparam int SLOT_FW   = 5;

    // Request codes
    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    typedef logic [REC_WORDS-1:0][WORD_W-1:0] t_rec;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [WORD_W-1:0] in_word_0;
        logic [WORD_W-1:0] in_word_1;
        logic [WORD_W-1:0] in_word_2;
        logic [WORD_W-1:0] in_word_3;
        logic [WORD_W-1:0] in_word_4;
        logic [WORD_W-1:0] in_word_5;
        logic [WORD_W-1:0] in_word_6;
        logic [WORD_W-1:0] in_word_7;
    } t_req;

    typedef struct packed {
        logic [WORD_W-1:0]  out_word_0;
        logic [WORD_W-1:0]  out_word_1;
        logic [WORD_W-1:0]  out_word_2;
        logic [WORD_W-1:0]  out_word_3;
        logic [WORD_W-1:0]  out_word_4;
        logic [WORD_W-1:0]  out_word_5;
        logic [WORD_W-1:0]  out_word_6;
        logic [WORD_W-1:0]  out_word_7;
        logic               record_valid;
        logic [SLOT_FW-1:0] slot_used;
    } t_rsp;

    // Write enables towards the slot store
    typedef struct packed {
        logic rec_we;
        logic idx_we;
    } t_store_wen;

    typedef enum logic {
        ALU_INC,
        ALU_SUB
    } t_alu_op;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN0,
        ST_SCAN1,
        ST_SCAN,
        ST_RD_ADDR,
        ST_RD_DATA,
        ST_SUM,
        ST_WR,
        ST_FINISH
    } t_state;

endpackage

/* rtl/wlrr_if.sv */
`timescale 1ns / 1ps

// Request channel
interface wlrr_req_if import wlrr_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Response channel
interface wlrr_rsp_if import wlrr_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/wear_leveled_record_ring.sv */
`timescale 1ns / 1ps
// Read: counter scan, row fetch, 8 checksum steps, result.
// Write: counter scan, 8 checksum steps, store, result.
// Clear: one slot zeroed per cycle, then the result; other codes go straight to the result.
// One request at a time; the next can be taken in the same cycle as the result is raised.
// Reset runs a clearing pass over every slot during which no request is taken.

module wear_leveled_record_ring import wlrr_pkg::*; #(
    parameter int SLOTS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    wlrr_req_if.sink          i_req,
    wlrr_rsp_if.source        o_rsp
);

    localparam int SW = $clog2(SLOTS);

    t_state            r_state,     n_state;
    logic [1:0]        r_req,       n_req;
    t_rec              r_words,     n_words;
    logic [SW-1:0]     r_i,         n_i;
    logic [SW-1:0]     r_ptr,       n_ptr;
    logic [SW-1:0]     r_cur,       n_cur;
    logic [WORD_W-1:0] r_prev,      n_prev;
    logic [WORD_W-1:0] r_acc,       n_acc;
    logic [WORD_W-1:0] r_chk,       n_chk;
    logic [2:0]        r_k,         n_k;
    logic              r_ok,        n_ok;
    logic              r_clr_reply, n_clr_reply;
    logic              r_out_valid, n_out_valid;
    t_rsp              r_out,       n_out;

    t_store_wen        s_wen;
    logic [SW-1:0]     s_rec_waddr;
    logic [WORD_W-1:0] s_chk_wdata;
    t_rec              s_rec_wdata;
    logic [SW-1:0]     s_idx_waddr;
    logic [WORD_W-1:0] s_idx_wdata;
    logic [SW-1:0]     s_idx_raddr;
    logic [SW-1:0]     s_newest;
    t_rec              s_rec_rd;
    logic [WORD_W-1:0] s_chk_rd;
    logic [WORD_W-1:0] s_idx_rd;
    t_alu_op           s_alu_op;
    logic [WORD_W-1:0] s_alu_a;
    logic [WORD_W-1:0] s_alu_b;
    logic [WORD_W-1:0] s_alu_y;
    logic              s_in_ready;

    function automatic logic [SW-1:0] f_inc(input logic [SW-1:0] x);
        return (x == SW'(SLOTS - 1)) ? '0 : x + 1'b1;
    endfunction

    wlrr_store #(.SLOTS(SLOTS)) u_store (
        .i_clk       (i_clk),
        .i_wen       (s_wen),
        .i_rec_waddr (s_rec_waddr),
        .i_rec_wdata (s_rec_wdata),
        .i_chk_wdata (s_chk_wdata),
        .i_rec_raddr (s_newest),
        .i_idx_waddr (s_idx_waddr),
        .i_idx_wdata (s_idx_wdata),
        .i_idx_raddr (s_idx_raddr),
        .o_rec_rdata (s_rec_rd),
        .o_chk_rdata (s_chk_rd),
        .o_idx_rdata (s_idx_rd)
    );

    wlrr_alu u_alu (
        .i_op (s_alu_op),
        .i_a  (s_alu_a),
        .i_b  (s_alu_b),
        .o_y  (s_alu_y)
    );

    // Newest slot sits one behind the current slot, with wraparound
    assign s_newest = (r_cur == '0) ? SW'(SLOTS - 1) : r_cur - 1'b1;

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_i         <= '0;
            r_clr_reply <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_i         <= n_i;
            r_clr_reply <= n_clr_reply;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold working data
    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_words <= n_words;
        r_ptr   <= n_ptr;
        r_cur   <= n_cur;
        r_prev  <= n_prev;
        r_acc   <= n_acc;
        r_chk   <= n_chk;
        r_k     <= n_k;
        r_ok    <= n_ok;
        r_out   <= n_out;
    end

    // Sequence one request through scan, checksum and store
    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_words     = r_words;
        n_i         = r_i;
        n_ptr       = r_ptr;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_acc       = r_acc;
        n_chk       = r_chk;
        n_k         = r_k;
        n_ok        = r_ok;
        n_clr_reply = r_clr_reply;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        s_in_ready  = 1'b0;
        s_wen       = '0;
        s_rec_waddr = r_cur;
        s_rec_wdata = r_words;
        s_chk_wdata = r_acc;
        s_idx_waddr = f_inc(r_cur);
        s_idx_wdata = s_alu_y;
        s_idx_raddr = r_ptr;
        s_alu_op    = ALU_INC;
        s_alu_a     = r_prev;
        s_alu_b     = r_words[r_k];

        // Drop the result once taken
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_CLEAR: begin
                s_wen.rec_we = 1'b1;
                s_wen.idx_we = 1'b1;
                s_rec_waddr  = r_i;
                s_rec_wdata  = '0;
                s_chk_wdata  = '0;
                s_idx_waddr  = r_i;
                s_idx_wdata  = '0;
                if (r_i == SW'(SLOTS - 1)) begin
                    n_i     = '0;
                    n_ok    = 1'b1;
                    n_cur   = '0;
                    n_state = r_clr_reply ? ST_FINISH : ST_IDLE;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            ST_IDLE: begin
                s_in_ready = 1'b1;
                if (i_req.valid) begin
                    n_req   = i_req.data.req_type;
                    n_words = {i_req.data.in_word_7, i_req.data.in_word_6,
                               i_req.data.in_word_5, i_req.data.in_word_4,
                               i_req.data.in_word_3, i_req.data.in_word_2,
                               i_req.data.in_word_1, i_req.data.in_word_0};
                    case (i_req.data.req_type)
                        REQ_READ, REQ_WRITE: begin
                            n_state = ST_SCAN0;
                        end
                        REQ_CLEAR: begin
                            n_i         = '0;
                            n_clr_reply = 1'b1;
                            n_state     = ST_CLEAR;
                        end
                        default: begin
                            n_ok    = 1'b0;
                            n_cur   = '0;
                            n_state = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_SCAN0: begin
                s_idx_raddr = '0;
                n_state     = ST_SCAN1;
            end
            ST_SCAN1: begin
                n_prev      = s_idx_rd;
                n_i         = '0;
                s_idx_raddr = f_inc('0);
                n_ptr       = f_inc('0);
                n_state     = ST_SCAN;
            end
            ST_SCAN: begin
                // Compare counter plus one with the next slot's counter
                if (s_alu_y != s_idx_rd) begin
                    n_cur = r_i;
                end else if (r_i == SW'(SLOTS - 1)) begin
                    n_cur  = '0;
                    n_prev = s_idx_rd;
                end else begin
                    n_prev = s_idx_rd;
                end
                if (s_alu_y != s_idx_rd || r_i == SW'(SLOTS - 1)) begin
                    n_i   = '0;
                    n_k   = '0;
                    n_acc = '0;
                    n_state = (r_req == REQ_READ) ? ST_RD_ADDR : ST_SUM;
                end else begin
                    n_i         = r_i + 1'b1;
                    n_ptr       = f_inc(r_ptr);
                    s_idx_raddr = f_inc(r_ptr);
                end
            end
            ST_RD_ADDR: begin
                n_state = ST_RD_DATA;
            end
            ST_RD_DATA: begin
                n_words = s_rec_rd;
                n_chk   = s_chk_rd;
                n_k     = '0;
                n_acc   = '0;
                n_state = ST_SUM;
            end
            ST_SUM: begin
                // Subtract one word a cycle
                s_alu_op = ALU_SUB;
                s_alu_a  = r_acc;
                n_acc    = s_alu_y;
                n_k      = r_k + 1'b1;
                if (r_k == 3'(REC_WORDS - 1)) begin
                    if (r_req == REQ_READ) begin
                        n_ok    = (s_alu_y == r_chk);
                        n_state = ST_FINISH;
                    end else begin
                        n_state = ST_WR;
                    end
                end
            end
            ST_WR: begin
                // Store row and checksum, advance the next counter
                s_wen.rec_we = 1'b1;
                s_wen.idx_we = 1'b1;
                n_ok         = 1'b1;
                n_state      = ST_FINISH;
            end
            ST_FINISH: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    if (r_req == REQ_READ) begin
                        n_out.out_word_0 = r_words[0];
                        n_out.out_word_1 = r_words[1];
                        n_out.out_word_2 = r_words[2];
                        n_out.out_word_3 = r_words[3];
                        n_out.out_word_4 = r_words[4];
                        n_out.out_word_5 = r_words[5];
                        n_out.out_word_6 = r_words[6];
                        n_out.out_word_7 = r_words[7];
                        n_out.slot_used  = SLOT_FW'(s_newest);
                    end else begin
                        n_out.slot_used  = SLOT_FW'(r_cur);
                    end
                    n_out.record_valid = r_ok;
                    n_state            = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign i_req.ready = s_in_ready;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

endmodule

/* rtl/wlrr_alu.sv */
`timescale 1ns / 1ps

module wlrr_alu import wlrr_pkg::*; (
    input  t_alu_op           i_op,
    input  logic [WORD_W-1:0] i_a,
    input  logic [WORD_W-1:0] i_b,
    output logic [WORD_W-1:0] o_y
);

    // Shared 16-bit adder: counter increment or checksum subtract
    always_comb begin
        case (i_op)
            ALU_INC: o_y = i_a + 1'b1;
            ALU_SUB: o_y = i_a - i_b;
            default: o_y = i_a;
        endcase
    end

endmodule

/* rtl/wlrr_store.sv */
`timescale 1ns / 1ps

module wlrr_store import wlrr_pkg::*; #(
    parameter int SLOTS = 32,
    localparam int SW   = $clog2(SLOTS)
) (
    input  logic              i_clk,
    input  t_store_wen        i_wen,
    input  logic [SW-1:0]     i_rec_waddr,
    input  t_rec              i_rec_wdata,
    input  logic [WORD_W-1:0] i_chk_wdata,
    input  logic [SW-1:0]     i_rec_raddr,
    input  logic [SW-1:0]     i_idx_waddr,
    input  logic [WORD_W-1:0] i_idx_wdata,
    input  logic [SW-1:0]     i_idx_raddr,
    output t_rec              o_rec_rdata,
    output logic [WORD_W-1:0] o_chk_rdata,
    output logic [WORD_W-1:0] o_idx_rdata
);

    t_rec              r_rec_mem [SLOTS];
    logic [WORD_W-1:0] r_chk_mem [SLOTS];
    logic [WORD_W-1:0] r_idx_mem [SLOTS];
    t_rec              r_rec_rd;
    logic [WORD_W-1:0] r_chk_rd;
    logic [WORD_W-1:0] r_idx_rd;

    // Record row and checksum share one address
    always_ff @(posedge i_clk) begin
        if (i_wen.rec_we) begin
            r_rec_mem[i_rec_waddr] <= i_rec_wdata;
            r_chk_mem[i_rec_waddr] <= i_chk_wdata;
        end
        r_rec_rd <= r_rec_mem[i_rec_raddr];
        r_chk_rd <= r_chk_mem[i_rec_raddr];
    end

    // Index counter ring
    always_ff @(posedge i_clk) begin
        if (i_wen.idx_we) begin
            r_idx_mem[i_idx_waddr] <= i_idx_wdata;
        end
        r_idx_rd <= r_idx_mem[i_idx_raddr];
    end

    assign o_rec_rdata = r_rec_rd;
    assign o_chk_rdata = r_chk_rd;
    assign o_idx_rdata = r_idx_rd;

endmodule

/* rtl/wlrr_chk.sv */
`timescale 1ns / 1ps

module wlrr_chk import wlrr_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input t_rsp i_out_data
);

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result beat changed while stalled");

    // One request at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken while busy");

    // Clearing pass follows reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("request taken before clearing pass");

    // A result only appears while the request side is busy
    a_rsp_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("result raised without a request in work");

endmodule

bind wear_leveled_record_ring wlrr_chk u_wlrr_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_data  (o_rsp.data)
);

/* sim/tb_wear_leveled_record_ring.sv */
`timescale 1ns / 1ps

module tb_wear_leveled_record_ring;
    import wlrr_pkg::*;

    localparam int SLOTS        = 32;
    localparam int N_RANDOM     = 1800;
    localparam int LIMIT_CYCLES = 600000;
    localparam int TAIL_CYCLES  = SLOTS + 20;
    localparam int LONG_HOLD    = 400;
    localparam int HOLD_AT_BEAT = 300;
    // Request code with no function in the block
    localparam logic [1:0] REQ_SPARE = 2'd3;

    typedef struct {
        t_req req;
        bit   drain;
    } t_req_item;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    wlrr_req_if req_if ();
    wlrr_rsp_if rsp_if ();

    wear_leveled_record_ring #(
        .SLOTS (SLOTS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Shadow copy of the slot store
    logic [WORD_W-1:0] idx_shadow [SLOTS];
    t_rec              rec_shadow [SLOTS];
    logic [WORD_W-1:0] chk_shadow [SLOTS];

    t_req_item pending_reqs [$];
    t_rsp      awaited_rsps [$];

    int n_accepted = 0;
    int n_checked  = 0;
    int n_fail     = 0;
    int cycles     = 0;
    int send_gap   = 0;
    int take_gap   = 0;
    bit send_busy;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic void wipe_shadow();
        for (int i = 0; i < SLOTS; i++) begin
            idx_shadow[i] = '0;
            rec_shadow[i] = '0;
            chk_shadow[i] = '0;
        end
    endfunction

    // Zero minus the sum of the eight words, modulo 2^16
    function automatic logic [WORD_W-1:0] neg_sum(t_rec w);
        logic [WORD_W-1:0] acc;
        acc = '0;
        for (int k = 0; k < REC_WORDS; k++) acc = acc - w[k];
        return acc;
    endfunction

    // First slot whose counter does not link to the next one
    function automatic int find_head();
        for (int i = 0; i < SLOTS; i++) begin
            if (idx_shadow[i] + 16'd1 != idx_shadow[(i + 1) % SLOTS]) return i;
        end
        return 0;
    endfunction

    // Work out the response to one request and update the shadow store
    function automatic t_rsp predict_ring_rsp(t_req r);
        t_rsp rsp;
        t_rec w;
        int   slot;
        rsp = '0;
        w = {r.in_word_7, r.in_word_6, r.in_word_5, r.in_word_4,
             r.in_word_3, r.in_word_2, r.in_word_1, r.in_word_0};
        case (r.req_type)
            REQ_READ: begin
                slot = find_head();
                slot = (slot == 0) ? SLOTS - 1 : slot - 1;
                w = rec_shadow[slot];
                rsp.out_word_0   = w[0];
                rsp.out_word_1   = w[1];
                rsp.out_word_2   = w[2];
                rsp.out_word_3   = w[3];
                rsp.out_word_4   = w[4];
                rsp.out_word_5   = w[5];
                rsp.out_word_6   = w[6];
                rsp.out_word_7   = w[7];
                rsp.record_valid = (neg_sum(w) == chk_shadow[slot]);
                rsp.slot_used    = SLOT_FW'(slot);
            end
            REQ_WRITE: begin
                slot = find_head();
                rec_shadow[slot] = w;
                chk_shadow[slot] = neg_sum(w);
                idx_shadow[(slot + 1) % SLOTS] = idx_shadow[slot] + 16'd1;
                rsp.record_valid = 1'b1;
                rsp.slot_used    = SLOT_FW'(slot);
            end
            REQ_CLEAR: begin
                wipe_shadow();
                rsp.record_valid = 1'b1;
            end
            default: ;
        endcase
        return rsp;
    endfunction

    function automatic void check_field(string name, logic [WORD_W-1:0] want,
                                        logic [WORD_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            n_fail++;
        end
    endfunction

    function automatic void check_rsp(t_rsp got);
        t_rsp want;
        if (awaited_rsps.size() == 0) begin
            $error("response beat with no request outstanding");
            n_fail++;
            return;
        end
        want = awaited_rsps.pop_front();
        check_field("out_word_0", want.out_word_0, got.out_word_0);
        check_field("out_word_1", want.out_word_1, got.out_word_1);
        check_field("out_word_2", want.out_word_2, got.out_word_2);
        check_field("out_word_3", want.out_word_3, got.out_word_3);
        check_field("out_word_4", want.out_word_4, got.out_word_4);
        check_field("out_word_5", want.out_word_5, got.out_word_5);
        check_field("out_word_6", want.out_word_6, got.out_word_6);
        check_field("out_word_7", want.out_word_7, got.out_word_7);
        check_field("record_valid", WORD_W'(want.record_valid), WORD_W'(got.record_valid));
        check_field("slot_used", WORD_W'(want.slot_used), WORD_W'(got.slot_used));
    endfunction

    // Idle cycles per beat; every third stretch of 250 beats runs flat out
    function automatic int pick_idle(int n);
        if ((n / 250) % 3 == 2) return 0;
        return $urandom_range(0, 14);
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 16'hFFFF;
            default: return WORD_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic t_rec rand_rec();
        t_rec w;
        for (int k = 0; k < REC_WORDS; k++) w[k] = rand_word();
        return w;
    endfunction

    function automatic void add_req(logic [1:0] code, t_rec w, bit drain);
        t_req_item it;
        it.req.req_type  = code;
        it.req.in_word_0 = w[0];
        it.req.in_word_1 = w[1];
        it.req.in_word_2 = w[2];
        it.req.in_word_3 = w[3];
        it.req.in_word_4 = w[4];
        it.req.in_word_5 = w[5];
        it.req.in_word_6 = w[6];
        it.req.in_word_7 = w[7];
        it.drain = drain;
        pending_reqs.push_back(it);
    endfunction

    // Request driver: offer the head of the queue, predict on each accepted beat
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            send_gap = 0;
        end else begin
            send_busy = req_if.valid;
            if (req_if.valid && req_if.ready) begin
                awaited_rsps.push_back(predict_ring_rsp(pending_reqs[0].req));
                void'(pending_reqs.pop_front());
                n_accepted++;
                send_gap  = pick_idle(n_accepted);
                send_busy = 1'b0;
            end
            if (!send_busy) begin
                if (send_gap > 0) begin
                    send_gap--;
                    req_if.valid <= 1'b0;
                end else if (pending_reqs.size() > 0 &&
                             !(pending_reqs[0].drain && n_checked != n_accepted)) begin
                    req_if.data  <= pending_reqs[0].req;
                    req_if.valid <= 1'b1;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor: check each beat, then stall for a drawn number of cycles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            take_gap = 0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                check_rsp(rsp_if.data);
                n_checked <= n_checked + 1;
                take_gap = pick_idle(n_checked);
                // Hold off long enough for the block to back up its input
                if (n_checked == HOLD_AT_BEAT) take_gap = LONG_HOLD;
            end
            if (take_gap > 0) begin
                take_gap--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        t_rec ones;
        t_rec mixed;
        int   made;
        int   episode;
        int   len;
        int   pick;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        rsp_if.ready = 1'b0;
        wipe_shadow();
        ones  = {REC_WORDS{16'hFFFF}};
        mixed = {16'h8000, 16'h0001, 16'h7FFF, 16'hFFFE,
                 16'h00FF, 16'hFF00, 16'h0F0F, 16'hF0F0};

        // Directed: empty store read wraps to the last slot, spare code, extremes
        add_req(REQ_READ,  '0, 1'b0);
        add_req(REQ_SPARE, ones, 1'b0);
        add_req(REQ_WRITE, '0, 1'b0);
        add_req(REQ_WRITE, ones, 1'b0);
        add_req(REQ_WRITE, {4{16'hAAAA, 16'h5555}}, 1'b0);
        add_req(REQ_READ,  '0, 1'b0);
        add_req(REQ_WRITE, mixed, 1'b0);
        add_req(REQ_READ,  ones, 1'b0);
        add_req(REQ_SPARE, '0, 1'b0);
        add_req(REQ_READ,  '0, 1'b0);
        add_req(REQ_CLEAR, ones, 1'b0);
        add_req(REQ_READ,  '0, 1'b0);
        add_req(REQ_WRITE, rand_rec(), 1'b0);
        add_req(REQ_READ,  '0, 1'b0);
        add_req(REQ_CLEAR, '0, 1'b1);
        add_req(REQ_READ,  '0, 1'b0);

        // Random: episodes that open with a clear, mostly writes and reads so the
        // ring wraps, with spare codes and stray clears as noise
        made    = 0;
        episode = 0;
        while (made < N_RANDOM) begin
            add_req(REQ_CLEAR, rand_rec(), episode % 5 == 4);
            made++;
            len = $urandom_range(10, 120);
            for (int j = 0; j < len; j++) begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    add_req(REQ_WRITE, rand_rec(), 1'b0);
                    made++;
                end else if (pick < 90) begin
                    add_req(REQ_READ, rand_rec(), 1'b0);
                    made++;
                end else if (pick < 95) begin
                    add_req(REQ_SPARE, rand_rec(), 1'b0);
                end else begin
                    add_req(REQ_CLEAR, rand_rec(), 1'b0);
                    made++;
                end
            end
            episode++;
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain, then let the block settle
        while (pending_reqs.size() > 0 || n_checked != n_accepted) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (awaited_rsps.size() != 0) begin
            $error("%0d responses never arrived", awaited_rsps.size());
            n_fail++;
        end
        if (n_fail == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/wlrr_pkg.sv
rtl/wlrr_if.sv
rtl/wlrr_alu.sv
rtl/wlrr_store.sv
rtl/wear_leveled_record_ring.sv
rtl/wlrr_chk.sv
sim/tb_wear_leveled_record_ring.sv
